@@ rtl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and arithmetic helpers for the rotation cipher.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned GEN_W   = 17;  // generator value, 1..65536
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROT_W   = 7;   // rotation amount, 0..95
  localparam int unsigned IDX_W   = 1;   // configuration register index

  localparam logic [GEN_W-1:0]  GEN_MULT   = 17'd75;
  localparam logic [GEN_W-1:0]  GEN_MAX    = 17'd65536;
  localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'd127;
  localparam logic [BYTE_W-1:0] PRINT_SPAN = 8'd96;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [IDX_W-1:0] REG_SEED = 1'd1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic             decrypt;
    logic [GEN_W-1:0] seed;
  } cfg_t;

  // Keep a generator value inside 1..65536
  function automatic logic [GEN_W-1:0] clamp_seed(input logic [GEN_W-1:0] s);
    logic [GEN_W-1:0] r;
    if (s == '0) begin
      r = GEN_W'(1);
    end else if (s > GEN_MAX) begin
      r = GEN_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // One Lehmer step: g * 75 mod 65537, folded as low half minus high part
  function automatic logic [GEN_W-1:0] advance(input logic [GEN_W-1:0] g);
    logic [23:0] prod;
    logic [15:0] lo;
    logic [7:0]  hi;
    logic [17:0] res;
    prod = 24'(clamp_seed(g)) * 24'(GEN_MULT);
    lo   = prod[15:0];
    hi   = prod[23:16];
    if (lo >= 16'(hi)) begin
      res = 18'(lo) - 18'(hi);
    end else begin
      res = 18'(lo) + 18'd65537 - 18'(hi);
    end
    return res[GEN_W-1:0];
  endfunction

  // x mod 3 for a 5-bit value (base-4 digit sum, then a small fold)
  function automatic logic [1:0] mod3_small(input logic [4:0] s);
    logic [2:0] t;
    logic [2:0] r;
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      r = t - 3'd6;
    end else if (t >= 3'd3) begin
      r = t - 3'd3;
    end else begin
      r = t;
    end
    return r[1:0];
  endfunction

  // g mod 96 = (g>>5 mod 3) * 32 + g[4:0]; 4 == 1 mod 3 gives a digit sum
  function automatic logic [ROT_W-1:0] mod96(input logic [GEN_W-1:0] g);
    logic [4:0] dsum;
    logic [1:0] m3;
    dsum = 5'(g[6:5]) + 5'(g[8:7]) + 5'(g[10:9]) + 5'(g[12:11])
         + 5'(g[14:13]) + 5'(g[16:15]);
    m3   = mod3_small(dsum);
    return {m3, g[4:0]};
  endfunction

  // Rotate a printable byte within 32..127; other bytes pass unchanged
  function automatic logic [BYTE_W-1:0] rotate(input logic [BYTE_W-1:0] b,
                                               input logic [ROT_W-1:0]  k,
                                               input logic              dec);
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] r;
    off = b - PRINT_LOW;
    if (dec) begin
      if (off >= 8'(k)) begin
        sum = off - 8'(k);
      end else begin
        sum = off + PRINT_SPAN - 8'(k);
      end
    end else begin
      sum = off + 8'(k);
      if (sum >= PRINT_SPAN) begin
        sum = sum - PRINT_SPAN;
      end
    end
    if (b < PRINT_LOW || b > PRINT_HIGH) begin
      r = b;
    end else begin
      r = sum + PRINT_LOW;
    end
    return r;
  endfunction

endpackage

@@ rtl/prc_if.sv @@
// ----------------------------------------------------------------------------
// prc_in_if / prc_out_if
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic                       valid;
  logic                       ready;
  logic [prc_pkg::BYTE_W-1:0] data_byte;
  logic                       start_of_message;

  modport source (output valid, output data_byte, output start_of_message, input ready);
  modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface prc_out_if;
  logic                       valid;
  logic                       ready;
  logic [prc_pkg::BYTE_W-1:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

@@ rtl/prc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// prc_cfg_regs
// Mode and seed registers behind the plain write port.
// ----------------------------------------------------------------------------
module prc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [prc_pkg::IDX_W-1:0] index,
  input  logic [prc_pkg::GEN_W-1:0] wdata,
  output prc_pkg::cfg_t             cfg
);

  logic                      mode_r;
  logic                      mode_nxt;
  logic [prc_pkg::GEN_W-1:0] seed_r;
  logic [prc_pkg::GEN_W-1:0] seed_nxt;

  // Register decode
  always_comb begin
    mode_nxt = mode_r;
    seed_nxt = seed_r;
    if (wr_en) begin
      unique case (index)
        prc_pkg::REG_MODE: mode_nxt = wdata[0];
        prc_pkg::REG_SEED: seed_nxt = wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      seed_r <= prc_pkg::GEN_W'(1);
    end else begin
      mode_r <= mode_nxt;
      seed_r <= seed_nxt;
    end
  end

  assign cfg.decrypt = mode_r;
  assign cfg.seed    = seed_r;

endmodule

@@ rtl/prc_gen.sv @@
// ----------------------------------------------------------------------------
// prc_gen
// Lehmer generator register, advanced once per accepted item.
// ----------------------------------------------------------------------------
module prc_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,   // item accepted this cycle
  input  logic                      start,  // reload from seed first
  input  prc_pkg::cfg_t             cfg,
  output logic [prc_pkg::GEN_W-1:0] gen
);

  logic [prc_pkg::GEN_W-1:0] gen_r;
  logic [prc_pkg::GEN_W-1:0] gen_nxt;
  logic [prc_pkg::GEN_W-1:0] base;

  // Reload or continue, then one multiply-and-fold step
  always_comb begin
    base    = start ? prc_pkg::clamp_seed(cfg.seed) : gen_r;
    gen_nxt = step ? prc_pkg::advance(base) : gen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= prc_pkg::GEN_W'(1);
    end else begin
      gen_r <= gen_nxt;
    end
  end

  assign gen = gen_r;

endmodule

@@ rtl/prc_rotate.sv @@
// ----------------------------------------------------------------------------
// prc_rotate
// Reduces the generator value mod 96, rotates the byte, holds the result.
// ----------------------------------------------------------------------------
module prc_rotate (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [prc_pkg::BYTE_W-1:0] in_byte,
  input  logic [prc_pkg::GEN_W-1:0]  gen,
  input  logic                       decrypt,
  output logic                       take,     // output register can load
  prc_out_if.source                  out_item
);

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [prc_pkg::BYTE_W-1:0] out_byte_r;
  logic [prc_pkg::BYTE_W-1:0] out_byte_nxt;
  logic [prc_pkg::ROT_W-1:0]  rot;

  assign take = !out_valid_r || out_item.ready;

  // Rotation datapath
  always_comb begin
    rot           = prc_pkg::mod96(gen);
    out_byte_nxt  = prc_pkg::rotate(in_byte, rot, decrypt);
    out_valid_nxt = take ? in_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded only when the slot is free or draining
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.result_byte = out_byte_r;

endmodule

@@ rtl/prng_rotation_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher_top
// Byte stream cipher: Lehmer generator (x75 mod 65537) drives a rotation
// of printable bytes within 32..127.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_item   in    valid/ready        data_byte[7:0], start_of_message
//  out_item  out   valid/ready        result_byte[7:0]
//  cfg_*     in    cfg_wr_en strobe   cfg_index (0 mode, 1 seed), cfg_wdata[16:0]
//
//  Throughput is one item per cycle while the output is not stalled; the
//  generator's multiply-by-75 and fold, closed through its own register, is the
//  loop that sets it. An item passes the input stage, then the result register.
//  Reset (rst_n low, synchronous) clears both valids, sets mode to encrypt,
//  seed to 1 and the generator to 1.
//  A stall at the output backs up through the input stage; in_item.ready
//  stays high while either stage has room or the output is draining.
// ----------------------------------------------------------------------------
module prng_rotation_stream_cipher_top (
  input  logic                      clk,
  input  logic                      rst_n,
  prc_in_if.sink                    in_item,
  prc_out_if.source                 out_item,
  input  logic                      cfg_wr_en,
  input  logic [prc_pkg::IDX_W-1:0] cfg_index,
  input  logic [prc_pkg::GEN_W-1:0] cfg_wdata
);

  prc_pkg::cfg_t              cfg;
  logic [prc_pkg::GEN_W-1:0]  gen;
  logic                       take;
  logic                       accept;
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic [prc_pkg::BYTE_W-1:0] s1_byte_r;

  prc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // Input stage handshake; the generator value tracks the item held here
  assign in_item.ready = !s1_valid_r || take;
  assign accept        = in_item.valid && in_item.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_item.ready) begin
      s1_valid_nxt = in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_item.data_byte;
    end
  end

  prc_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .start (in_item.start_of_message),
    .cfg   (cfg),
    .gen   (gen)
  );

  prc_rotate u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid_r),
    .in_byte  (s1_byte_r),
    .gen      (gen),
    .decrypt  (cfg.decrypt),
    .take     (take),
    .out_item (out_item)
  );

endmodule

@@ rtl/prc_checker.sv @@
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks on the cipher's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [prc_pkg::BYTE_W-1:0] result_byte
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_byte))
    else $error("result item changed while stalled");

  // A draining output never blocks the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // Nothing appears at the output right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind prng_rotation_stream_cipher_top prc_checker u_prc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .result_byte (out_item.result_byte)
);

@@ tb/sv/tb_prng_rotation_stream_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prng_rotation_stream_cipher_top
// Self-checking bench for the Lehmer-driven printable rotation cipher. A
// behavioral copy of the generator and the rotation predicts each result
// byte when an item is accepted, and the checker compares every result with
// the oldest prediction. Directed items cover reset defaults, seed and byte
// extremes in both modes. Random messages then run under idling on both
// sides, and a final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_prng_rotation_stream_cipher_top;

  localparam int unsigned LEHMER_MOD = 65537;
  localparam int unsigned DRAIN_LIMIT = 5000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en;
  logic [prc_pkg::IDX_W-1:0]  cfg_index;
  logic [prc_pkg::GEN_W-1:0]  cfg_wdata;

  prc_in_if  in_ch ();
  prc_out_if out_ch ();

  prng_rotation_stream_cipher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: register copies and the generator
  logic                       model_decrypt = 1'b0;
  logic [prc_pkg::GEN_W-1:0]  model_seed = prc_pkg::GEN_W'(1);
  logic [prc_pkg::GEN_W-1:0]  lehmer_state = prc_pkg::GEN_W'(1);
  logic [prc_pkg::BYTE_W-1:0] expected_bytes[$];

  int mismatch_count = 0;
  int items_sent = 0;
  bit gaps_en = 1'b0;
  bit stall_en = 1'b0;
  int stall_left = 0;

  // Seed zero would lock the generator; values past 65536 saturate
  function automatic logic [prc_pkg::GEN_W-1:0] seed_in_range(
      input logic [prc_pkg::GEN_W-1:0] s);
    if (s == '0) begin
      return prc_pkg::GEN_W'(1);
    end
    if (s > prc_pkg::GEN_MAX) begin
      return prc_pkg::GEN_MAX;
    end
    return s;
  endfunction

  function automatic logic [prc_pkg::GEN_W-1:0] lehmer_next(
      input logic [prc_pkg::GEN_W-1:0] g);
    int unsigned prod;
    prod = seed_in_range(g);
    prod = (prod * 75) % LEHMER_MOD;
    return prc_pkg::GEN_W'(prod);
  endfunction

  // Rotate within the 96 printable symbols; anything else is untouched
  function automatic logic [prc_pkg::BYTE_W-1:0] shift_printable(
      input logic [prc_pkg::BYTE_W-1:0] b,
      input logic [prc_pkg::GEN_W-1:0]  g,
      input logic                       dec);
    int unsigned off;
    int unsigned k;
    if (b < prc_pkg::PRINT_LOW || b > prc_pkg::PRINT_HIGH) begin
      return b;
    end
    off = b - prc_pkg::PRINT_LOW;
    k = g % prc_pkg::PRINT_SPAN;
    if (dec) begin
      off = (off + prc_pkg::PRINT_SPAN - k) % prc_pkg::PRINT_SPAN;
    end else begin
      off = (off + k) % prc_pkg::PRINT_SPAN;
    end
    return prc_pkg::BYTE_W'(off + prc_pkg::PRINT_LOW);
  endfunction

  // Advance the generator for one byte and return its cipher byte
  function automatic logic [prc_pkg::BYTE_W-1:0] cipher_byte(
      input logic [prc_pkg::BYTE_W-1:0] b,
      input logic                       som);
    if (som) begin
      lehmer_state = seed_in_range(model_seed);
    end
    lehmer_state = lehmer_next(lehmer_state);
    return shift_printable(b, lehmer_state, model_decrypt);
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic [prc_pkg::BYTE_W-1:0] want,
                                        input logic [prc_pkg::BYTE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ERROR %s: expected %02h, got %02h", $realtime, what, want, got);
    end
  endfunction

  // Check results, then record the prediction for a newly accepted item
  always @(posedge clk) begin : check_results
    logic [prc_pkg::BYTE_W-1:0] want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch("result_byte with no item pending", 'x, out_ch.result_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.result_byte !== want) begin
            note_mismatch("result_byte", want, out_ch.result_byte);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_bytes.push_back(cipher_byte(in_ch.data_byte, in_ch.start_of_message));
      end
    end
  end

  // Result side: random stall bursts when stalls are enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Send one item; called at a falling edge, returns at a falling edge.
  // Valid stays high into the next item unless a gap is inserted.
  task automatic send_item(input logic [prc_pkg::BYTE_W-1:0] b, input logic som);
    if (gaps_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.start_of_message = som;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait for every predicted result to come back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [prc_pkg::IDX_W-1:0] idx,
                           input logic [prc_pkg::GEN_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == prc_pkg::REG_MODE) begin
      model_decrypt = value[0];
    end else begin
      model_seed = value;
    end
  endtask

  task automatic set_config(input logic dec, input logic [prc_pkg::GEN_W-1:0] seed);
    wait_drained();
    cfg_write(prc_pkg::REG_MODE, prc_pkg::GEN_W'(dec));
    cfg_write(prc_pkg::REG_SEED, seed);
  endtask

  // Mostly legal seeds, sometimes the edges and out-of-range values
  function automatic logic [prc_pkg::GEN_W-1:0] pick_seed();
    if ($urandom_range(0, 9) != 0) begin
      return prc_pkg::GEN_W'($urandom_range(1, 65536));
    end
    case ($urandom_range(0, 5))
      0: return '0;
      1: return prc_pkg::GEN_W'(1);
      2: return prc_pkg::GEN_MAX;
      3: return prc_pkg::GEN_W'(65537);
      4: return '1;
      default: return prc_pkg::GEN_W'($urandom);
    endcase
  endfunction

  // Text-heavy bytes with some control and high bytes mixed in
  function automatic logic [prc_pkg::BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 9) < 7) begin
      return prc_pkg::BYTE_W'($urandom_range(32, 127));
    end
    return prc_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // One message: start flag on the first byte when restart is set, stray restarts when noisy
  task automatic send_message(input int len, input bit noisy, input bit restart);
    logic som;
    for (int i = 0; i < len; i++) begin
      som = (i == 0 && restart) || (noisy && $urandom_range(0, 19) == 0);
      send_item(pick_byte(), som);
    end
  endtask

  // No start flag yet: generator runs on from its reset value, encrypting
  task automatic test_after_reset();
    send_item(8'd32, 1'b0);
    send_item(8'd127, 1'b0);
    send_item(8'd31, 1'b0);
    send_item(8'd128, 1'b0);
  endtask

  // Seed zero, largest seed, saturating seeds, byte-range edges, both modes
  task automatic test_field_extremes();
    set_config(1'b0, '0);
    send_item(8'd32, 1'b1);
    send_item(8'd127, 1'b0);
    set_config(1'b0, prc_pkg::GEN_MAX);
    send_item(8'd255, 1'b1);
    send_item(8'd0, 1'b0);
    set_config(1'b1, '1);
    send_item(8'd32, 1'b1);
    send_item(8'd127, 1'b0);
    set_config(1'b1, prc_pkg::GEN_W'(65537));
    send_item(8'd65, 1'b1);
    send_item(8'd126, 1'b0);
    set_config(1'b1, prc_pkg::GEN_W'(1));
    send_item(8'd33, 1'b1);
    send_item(8'd96, 1'b0);
    send_item(8'd31, 1'b0);
    send_item(8'd128, 1'b0);
  endtask

  // Phases of random settings, each carrying a few messages
  task automatic test_random_traffic(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      set_config(1'($urandom_range(0, 1)), pick_seed());
      repeat ($urandom_range(1, 6)) begin
        send_message($urandom_range(1, 48), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7) != 0);
      end
    end
  endtask

  // Sender holds off until all results are back, then the message resumes
  task automatic test_sender_pause();
    set_config(1'b0, pick_seed());
    send_message(20, 1'b0, 1'b1);
    wait_drained();
    send_message(20, 1'b0, 1'b0);
  endtask

  task automatic test_full_rate(input int count);
    set_config(1'b1, pick_seed());
    send_message(count / 2, 1'b0, 1'b1);
    set_config(1'b0, pick_seed());
    send_message(count - count / 2, 1'b1, 1'b1);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_message = 1'b0;
    out_ch.ready = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = prc_pkg::REG_MODE;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_field_extremes();
    gaps_en = 1'b1;
    stall_en = 1'b1;
    test_random_traffic(1050);
    test_sender_pause();
    gaps_en = 1'b0;
    stall_en = 1'b0;
    test_full_rate(180);

    // Let the last results drain, bounded
    in_ch.valid = 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && expected_bytes.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
